// File: src/phd_pkg.sv
// ----------------------------------------------------------------------------
// phd_pkg
// Shared types, codes and the falling-factorial weight table of the
// polynomial derivative evaluator.
// ----------------------------------------------------------------------------
package phd_pkg;

    // item opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    // configuration register byte addresses
    localparam logic [1:0] REG_ADDR_POLY_DEGREE = 2'd0;

    // highest coefficient index the input fields can name
    localparam int MAX_INDEX = 15;

    // weight cap, 2^63
    localparam logic [63:0] WEIGHT_CAP = 64'h8000_0000_0000_0000;

    // wide accumulator for one horner step
    localparam int SUM_W = 114;

    // coefficient store write request
    typedef struct packed {
        logic        en;
        logic [3:0]  idx;
        logic [31:0] data;
    } coef_wr_t;

    // falling factorial j!/(j-k)!, indexed by {j, k}
    typedef logic [255:0][63:0] wtbl_t;

    // entries actually kept in the coefficient store
    function automatic int store_depth(int max_degree);
        int d;
        d = (max_degree < MAX_INDEX) ? max_degree : MAX_INDEX;
        return d + 1;
    endfunction

    // build the weight table, holding values at the cap
    function automatic wtbl_t build_wtbl();
        wtbl_t       tbl;
        logic [67:0] prod;
        logic [63:0] w;
        for (int j = 0; j < 16; j++) begin
            for (int k = 0; k < 16; k++) begin
                w = 64'd1;
                if (k > j) begin
                    w = 64'd0;
                end
                else begin
                    for (int i = 0; i < k; i++) begin
                        prod = 68'(w) * 68'(j - i);
                        if (prod > 68'(WEIGHT_CAP)) begin
                            w = WEIGHT_CAP;
                        end
                        else begin
                            w = prod[63:0];
                        end
                    end
                end
                tbl[j * 16 + k] = w;
            end
        end
        return tbl;
    endfunction

    localparam wtbl_t WEIGHT_TBL = build_wtbl();

endpackage

// File: src/phd_coef_store.sv
// ----------------------------------------------------------------------------
// phd_coef_store
// Coefficient store: one write port, one registered read port, cleared at reset.
// ----------------------------------------------------------------------------
module phd_coef_store
    import phd_pkg::*;
#(
    parameter int MAX_DEGREE = 15
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  coef_wr_t                      wr,
    input  logic                          rd_en,
    input  logic [$clog2(store_depth(MAX_DEGREE))-1:0] rd_addr,
    output logic signed [31:0]            rd_data
);

    localparam int STORE_DEPTH = store_depth(MAX_DEGREE);
    localparam int AW          = $clog2(STORE_DEPTH);

    logic [31:0]      store_reg [STORE_DEPTH];
    logic [31:0]      rd_data_reg;
    logic             wr_ok;

    // indexes beyond the store are dropped
    assign wr_ok = wr.en && (32'(wr.idx) <= MAX_DEGREE);

    // store array and registered read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STORE_DEPTH; i++)
            begin
                store_reg[i] <= 32'd0;
            end
            rd_data_reg <= 32'd0;
        end
        else
        begin
            if (wr_ok)
            begin
                store_reg[AW'(wr.idx)] <= wr.data;
            end
            if (rd_en)
            begin
                rd_data_reg <= store_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/phd_mul_unit.sv
// ----------------------------------------------------------------------------
// phd_mul_unit
// Shared 33x33 signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module phd_mul_unit
(
    input  logic               clk,
    input  logic signed [32:0] a,
    input  logic signed [32:0] b,
    output logic signed [65:0] p
);

    logic signed [65:0] p_reg;

    // one product per cycle
    always_ff @(posedge clk)
    begin
        p_reg <= 66'(a) * 66'(b);
    end

    assign p = p_reg;

endmodule

// File: src/phd_ctrl.sv
// ----------------------------------------------------------------------------
// phd_ctrl
// Horner sequencer: steps the coefficient index down, drives the shared
// multiplier and folds its products into a wide accumulator with saturation.
// ----------------------------------------------------------------------------
module phd_ctrl
    import phd_pkg::*;
#(
    parameter int MAX_DEGREE = 15
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          eval_go,
    input  logic signed [31:0]            x_value,
    input  logic [4:0]                    deriv_order,
    input  logic [3:0]                    poly_degree,
    output logic                          busy,
    output logic                          rd_en,
    output logic [$clog2(store_depth(MAX_DEGREE))-1:0] rd_addr,
    input  logic signed [31:0]            rd_data,
    output logic signed [32:0]            mul_a,
    output logic signed [32:0]            mul_b,
    input  logic signed [65:0]            mul_p,
    output logic                          result_valid,
    output logic signed [63:0]            result_value,
    output logic                          overflow
);

    localparam int STORE_DEPTH = store_depth(MAX_DEGREE);
    localparam int AW          = $clog2(STORE_DEPTH);
    localparam logic [AW-1:0] TOP_IDX = AW'(STORE_DEPTH - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_M0,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_ACC
    } state_t;

    state_t                    state_reg;
    logic [AW-1:0]             j_reg;
    logic [3:0]                k_reg;
    logic signed [31:0]        x_reg;
    logic [63:0]               weight_reg;
    logic [63:0]               acc_reg;
    logic                      ovf_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic signed [SUM_W-1:0]   sum_next;
    logic                      result_valid_reg;
    logic signed [63:0]        result_value_reg;
    logic                      overflow_reg;

    logic [AW-1:0]             deg_eff;
    logic signed [SUM_W-1:0]   prod_ext;
    logic signed [SUM_W-1:0]   total;
    logic                      fits;
    logic [63:0]               sat_val;

    // degree clamped to the store size
    assign deg_eff = (32'(poly_degree) > MAX_DEGREE) ? TOP_IDX : AW'(poly_degree);

    assign busy    = (state_reg != ST_IDLE);
    assign rd_en   = (state_reg == ST_FETCH);
    assign rd_addr = j_reg;

    // multiplier operand select: acc*x in two halves, then weight*c in two halves
    always_comb
    begin
        case (state_reg)
            ST_M0:
            begin
                mul_a = {1'b0, acc_reg[31:0]};
                mul_b = {x_reg[31], x_reg};
            end
            ST_M1:
            begin
                mul_a = {acc_reg[63], acc_reg[63:32]};
                mul_b = {x_reg[31], x_reg};
            end
            ST_M2:
            begin
                mul_a = {1'b0, weight_reg[31:0]};
                mul_b = {rd_data[31], rd_data};
            end
            ST_M3:
            begin
                mul_a = {1'b0, weight_reg[63:32]};
                mul_b = {rd_data[31], rd_data};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // accumulate the partial products of one step
    assign prod_ext = {{(SUM_W - 66){mul_p[65]}}, mul_p};

    always_comb
    begin
        case (state_reg)
            ST_M1:   sum_next = prod_ext + SUM_W'(32'h0000_8000);
            ST_M2:   sum_next = sum_reg + (prod_ext <<< 32);
            ST_M3:   sum_next = (sum_reg >>> 16) + (prod_ext <<< 16);
            default: sum_next = sum_reg;
        endcase
    end

    // last partial product and clamp to 64 bits
    assign total   = sum_reg + (prod_ext <<< 48);
    assign fits    = (total[SUM_W-1:63] == '0) || (total[SUM_W-1:63] == '1);
    assign sat_val = fits ? total[63:0]
                   : (total[SUM_W-1] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF);

    // sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            j_reg            <= '0;
            k_reg            <= '0;
            x_reg            <= '0;
            weight_reg       <= '0;
            acc_reg          <= '0;
            ovf_reg          <= 1'b0;
            sum_reg          <= '0;
            result_valid_reg <= 1'b0;
            result_value_reg <= '0;
            overflow_reg     <= 1'b0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            sum_reg          <= sum_next;
            case (state_reg)
                ST_IDLE:
                begin
                    if (eval_go)
                    begin
                        if (deriv_order > 5'(deg_eff))
                        begin
                            // order above degree gives zero
                            result_valid_reg <= 1'b1;
                            result_value_reg <= '0;
                            overflow_reg     <= 1'b0;
                        end
                        else
                        begin
                            j_reg     <= deg_eff;
                            k_reg     <= deriv_order[3:0];
                            x_reg     <= x_value;
                            acc_reg   <= '0;
                            ovf_reg   <= 1'b0;
                            state_reg <= ST_FETCH;
                        end
                    end
                end
                ST_FETCH:
                begin
                    weight_reg <= WEIGHT_TBL[{4'(j_reg), k_reg}];
                    state_reg  <= ST_M0;
                end
                ST_M0:
                begin
                    state_reg <= ST_M1;
                end
                ST_M1:
                begin
                    state_reg <= ST_M2;
                end
                ST_M2:
                begin
                    state_reg <= ST_M3;
                end
                ST_M3:
                begin
                    state_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    acc_reg <= sat_val;
                    ovf_reg <= ovf_reg | ~fits;
                    if (4'(j_reg) == k_reg)
                    begin
                        result_valid_reg <= 1'b1;
                        result_value_reg <= sat_val;
                        overflow_reg     <= ovf_reg | ~fits;
                        state_reg        <= ST_IDLE;
                    end
                    else
                    begin
                        j_reg     <= j_reg - AW'(1);
                        state_reg <= ST_FETCH;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign result_value = result_value_reg;
    assign overflow     = overflow_reg;

endmodule

// File: src/poly_derivative_horner_eval_top.sv
// ----------------------------------------------------------------------------
// poly_derivative_horner_eval_top
// Stores Q16.16 polynomial coefficients and returns the k-th derivative at a
// point in Q32.32 by Horner's rule with falling-factorial weights, saturated.
//
//   channel   signals                                     transfer
//   item in   start, busy, opcode, coeff_index,           start & !busy
//             coeff_value, x_value, deriv_order
//   result    result_valid, result_value, overflow        result_valid (1 cycle)
//   config    psel, penable, pwrite, paddr, pwdata,       psel & penable & pready
//             prdata, pready
//
// A coefficient load is written to the store at its transfer and leaves busy low.
// An evaluate steps through each coefficient from index degree down to k in the
// states FETCH, M0 to M3 and ACC (a store read, four products on the one 33x33
// multiplier and a clamp); the result strobes in the cycle after the last step.
// An order above the degree gives its zero result in the cycle after transfer.
// Reset clears the store and the degree register; no clearing pass is needed.
// The result strobe is not held: the receiver takes it in that cycle.
// ----------------------------------------------------------------------------
module poly_derivative_horner_eval_top
    import phd_pkg::*;
#(
    parameter int MAX_DEGREE = 15
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               opcode,
    input  logic [3:0]         coeff_index,
    input  logic signed [31:0] coeff_value,
    input  logic signed [31:0] x_value,
    input  logic [4:0]         deriv_order,
    output logic               result_valid,
    output logic signed [63:0] result_value,
    output logic               overflow,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int STORE_DEPTH = store_depth(MAX_DEGREE);
    localparam int AW          = $clog2(STORE_DEPTH);

    logic [3:0]          poly_degree_reg;
    logic                accept;
    logic                eval_go;
    coef_wr_t            coef_wr;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic signed [31:0]  rd_data;
    logic signed [32:0]  mul_a;
    logic signed [32:0]  mul_b;
    logic signed [65:0]  mul_p;

    // configuration register
    assign pready = 1'b1;
    assign prdata = (paddr == REG_ADDR_POLY_DEGREE) ? {28'd0, poly_degree_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_degree_reg <= 4'd0;
        end
        else if (psel && penable && pwrite && pready && (paddr == REG_ADDR_POLY_DEGREE))
        begin
            poly_degree_reg <= pwdata[3:0];
        end
    end

    // item transfer decode
    assign accept       = start && !busy;
    assign eval_go      = accept && (opcode == OP_EVAL);
    assign coef_wr.en   = accept && (opcode == OP_LOAD);
    assign coef_wr.idx  = coeff_index;
    assign coef_wr.data = coeff_value;

    phd_coef_store #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (coef_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    phd_mul_unit u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    phd_ctrl #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .eval_go      (eval_go),
        .x_value      (x_value),
        .deriv_order  (deriv_order),
        .poly_degree  (poly_degree_reg),
        .busy         (busy),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .mul_a        (mul_a),
        .mul_b        (mul_b),
        .mul_p        (mul_p),
        .result_valid (result_valid),
        .result_value (result_value),
        .overflow     (overflow)
    );

endmodule

// File: src/phd_checker.sv
// ----------------------------------------------------------------------------
// phd_checker
// Port-level checks of the evaluator: item transfer, busy and result timing.
// ----------------------------------------------------------------------------
module phd_checker
    import phd_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic opcode,
    input logic result_valid,
    input logic pready
);

    // busy only starts from an evaluate transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && (opcode == OP_EVAL)))
        else $error("busy rose without an evaluate transfer");

    // a coefficient load gives no result and no busy period
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (opcode == OP_LOAD)) |=> (!busy && !result_valid))
        else $error("load transfer caused busy or a result");

    // a result follows an evaluate transfer or the end of a busy period
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ($past(start && !busy && (opcode == OP_EVAL)) || $past(busy)))
        else $error("result strobe without a pending evaluate");

    // the end of a busy period delivers its result
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_valid)
        else $error("busy ended without a result");

    // configuration port never waits
    assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind poly_derivative_horner_eval_top phd_checker u_phd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .result_valid (result_valid),
    .pready       (pready)
);

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for poly_derivative_horner_eval_top. A table of directed items
// comes first, then random phases that each set a degree over the config
// port and send mixed coefficient loads and derivative evaluations. Directed
// rows may give the expected result and overflow flag; otherwise a shadow coefficient
// store and a Horner predictor with capped falling-factorial weights supply them.
// ----------------------------------------------------------------------------
module tb;
    import phd_pkg::*;

    localparam int N_DIRECTED  = 26;
    localparam int NUM_PHASES  = 12;
    localparam int PER_PHASE   = 136;
    localparam int STALL_LIMIT = 2000;

    localparam logic signed [127:0] SAT_MAX = 128'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [127:0] SAT_MIN = ~SAT_MAX;

    typedef enum logic [1:0] {ROW_CFG, ROW_LOAD, ROW_EVAL} row_kind_t;

    // one directed row; num is the coefficient index or the degree
    typedef struct packed {
        row_kind_t   kind;
        logic [3:0]  num;
        logic [31:0] cval;
        logic [31:0] xval;
        logic [4:0]  k;
        logic        known;
        logic [63:0] exp_val;
        logic        exp_ovf;
    } dir_row_t;

    typedef struct packed {
        logic signed [63:0] value;
        logic               ovf;
    } deriv_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               opcode = OP_LOAD;
    logic [3:0]         coeff_index = 4'd0;
    logic signed [31:0] coeff_value = 32'sd0;
    logic signed [31:0] x_value = 32'sd0;
    logic [4:0]         deriv_order = 5'd0;
    logic               result_valid;
    logic signed [63:0] result_value;
    logic               overflow;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [1:0]         paddr = 2'd0;
    logic [31:0]        pwdata = 32'd0;
    logic [31:0]        prdata;
    logic               pready;

    // shadow state of the block
    logic signed [31:0] coef_shadow [16];
    logic [3:0]         degree_shadow = 4'd0;
    deriv_t             pending_derivs [$];

    int mismatch_count = 0;
    int idle_cycles = 0;

    // directed items: reset state, extremes, order above degree, saturation
    dir_row_t directed_rows [N_DIRECTED] = '{
        '{ROW_EVAL, 4'd0,  32'h0,        32'h0,        5'd0,  1'b1, 64'h0, 1'b0},
        '{ROW_EVAL, 4'd0,  32'h0,        32'h7FFF_FFFF, 5'd31, 1'b1, 64'h0, 1'b0},
        '{ROW_LOAD, 4'd0,  32'h7FFF_FFFF, 32'h0,        5'd0,  1'b0, 64'h0, 1'b0},
        '{ROW_EVAL, 4'd0,  32'h0,        32'h8000_0000, 5'd0,  1'b1,
          64'h0000_7FFF_FFFF_0000, 1'b0},
        '{ROW_EVAL, 4'd0,  32'h0,        32'h0,        5'd1,  1'b1, 64'h0, 1'b0},
        '{ROW_CFG,  4'd15, 32'h0,        32'h0,        5'd0,  1'b0, 64'h0, 1'b0},
        '{ROW_LOAD, 4'd15, 32'h7FFF_FFFF, 32'h0,        5'd0,  1'b0, 64'h0, 1'b0},
        '{ROW_EVAL, 4'd0,  32'h0,        32'h0,        5'd15, 1'b1,
          64'h7FFF_FFFF_FFFF_FFFF, 1'b1},
        '{ROW_EVAL, 4'd0,  32'h0,        32'h0001_2345, 5'd16, 1'b1, 64'h0, 1'b0},
        '{ROW_LOAD, 4'd15, 32'h8000_0000, 32'h0,        5'd0,  1'b0, 64'h0, 1'b0},
        '{ROW_EVAL, 4'd0,  32'h0,        32'h7FFF_FFFF, 5'd15, 1'b1,
          64'h8000_0000_0000_0000, 1'b1},
        '{ROW_LOAD, 4'd15, 32'h0,        32'h0,        5'd0,  1'b0, 64'h0, 1'b0},
        '{ROW_LOAD, 4'd0,  32'h8000_0000, 32'h0,        5'd0,  1'b0, 64'h0, 1'b0},
        '{ROW_EVAL, 4'd0,  32'h0,        32'h0,        5'd0,  1'b1,
          64'hFFFF_8000_0000_0000, 1'b0},
        '{ROW_LOAD, 4'd1,  32'h0001_0000, 32'h0,        5'd0,  1'b0, 64'h0, 1'b0},
        '{ROW_LOAD, 4'd7,  32'hFFFF_8000, 32'h0,        5'd0,  1'b0, 64'h0, 1'b0},
        '{ROW_EVAL, 4'd0,  32'h0,        32'h0001_0000, 5'd0,  1'b0, 64'h0, 1'b0},
        '{ROW_EVAL, 4'd0,  32'h0,        32'h8000_0000, 5'd1,  1'b0, 64'h0, 1'b0},
        '{ROW_EVAL, 4'd0,  32'h0,        32'h7FFF_FFFF, 5'd7,  1'b0, 64'h0, 1'b0},
        '{ROW_EVAL, 4'd0,  32'h0,        32'h0000_0001, 5'd0,  1'b0, 64'h0, 1'b0},
        '{ROW_EVAL, 4'd0,  32'h0,        32'hFFFF_FFFF, 5'd14, 1'b0, 64'h0, 1'b0},
        '{ROW_CFG,  4'd3,  32'h0,        32'h0,        5'd0,  1'b0, 64'h0, 1'b0},
        '{ROW_LOAD, 4'd3,  32'h0002_0000, 32'h0,        5'd0,  1'b0, 64'h0, 1'b0},
        '{ROW_EVAL, 4'd0,  32'h0,        32'hFFFE_0000, 5'd3,  1'b0, 64'h0, 1'b0},
        '{ROW_EVAL, 4'd0,  32'h0,        32'h0001_8000, 5'd2,  1'b0, 64'h0, 1'b0},
        '{ROW_EVAL, 4'd0,  32'h0,        32'h0001_8000, 5'd4,  1'b1, 64'h0, 1'b0}
    };

    poly_derivative_horner_eval_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .coeff_index  (coeff_index),
        .coeff_value  (coeff_value),
        .x_value      (x_value),
        .deriv_order  (deriv_order),
        .result_valid (result_valid),
        .result_value (result_value),
        .overflow     (overflow),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 clk = ~clk;

    // j!/(j-k)!, held at 2^63
    function automatic logic [127:0] falling_weight(input int j, input int k);
        logic [127:0] w;
        w = 128'd1;
        for (int i = 0; i < k; i++)
        begin
            w = w * 128'(j - i);
            if (w > 128'(WEIGHT_CAP))
            begin
                w = 128'(WEIGHT_CAP);
            end
        end
        return w;
    endfunction

    // k-th derivative at x by horner's rule, saturating each step
    function automatic deriv_t predict_derivative(input logic signed [31:0] xval,
                                                  input logic [4:0] k);
        logic signed [127:0] acc;
        logic signed [127:0] xw;
        logic signed [127:0] cw;
        logic signed [127:0] prod;
        logic signed [127:0] term;
        logic signed [127:0] sum;
        deriv_t              res;
        int                  kk;
        int                  deg;
        acc = '0;
        xw  = xval;
        kk  = int'(k);
        deg = int'(degree_shadow);
        res.ovf = 1'b0;
        if (kk <= deg)
        begin
            for (int j = deg; j >= kk; j--)
            begin
                cw   = coef_shadow[j];
                prod = (acc * xw + 128'sd32768) >>> 16;
                term = ($signed(falling_weight(j, kk)) * cw) <<< 16;
                sum  = prod + term;
                if (sum > SAT_MAX)
                begin
                    acc = SAT_MAX;
                    res.ovf = 1'b1;
                end
                else if (sum < SAT_MIN)
                begin
                    acc = SAT_MIN;
                    res.ovf = 1'b1;
                end
                else
                begin
                    acc = sum;
                end
            end
        end
        res.value = acc[63:0];
        return res;
    endfunction

    // random q16.16 value: small, full range or an extreme
    function automatic logic [31:0] pick_q16(input int unsigned span);
        int unsigned sel;
        logic [31:0] v;
        sel = $urandom_range(0, 99);
        if (sel < 45)
        begin
            v = $urandom_range(0, 2 * span) - span;
        end
        else if (sel < 85)
        begin
            v = $urandom;
        end
        else
        begin
            case ($urandom_range(0, 5))
                0:       v = 32'h7FFF_FFFF;
                1:       v = 32'h8000_0000;
                2:       v = 32'h0000_0000;
                3:       v = 32'h0001_0000;
                4:       v = 32'hFFFF_0000;
                default: v = 32'hFFFF_FFFF;
            endcase
        end
        return v;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("%s", msg);
        end
    endtask

    // present one item and hold it until the transfer, then update the shadow
    task automatic issue_item(input logic op, input logic [3:0] idx,
                              input logic [31:0] cval, input logic [31:0] xval,
                              input logic [4:0] k, input logic known,
                              input deriv_t typed_res);
        logic taken;
        start       <= 1'b1;
        opcode      <= op;
        coeff_index <= idx;
        coeff_value <= cval;
        x_value     <= xval;
        deriv_order <= k;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        if (op == OP_LOAD)
        begin
            coef_shadow[idx] = cval;
        end
        else
        begin
            pending_derivs.push_back(known ? typed_res : predict_derivative(xval, k));
        end
    endtask

    // drain, then write the degree register and read it back
    task automatic write_degree(input logic [3:0] deg);
        logic        rdy;
        logic [31:0] rd;
        start <= 1'b0;
        while (pending_derivs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_ADDR_POLY_DEGREE;
        pwdata  <= {28'($urandom), deg};
        @(posedge clk);
        penable <= 1'b1;
        rdy = 1'b0;
        while (!rdy)
        begin
            @(negedge clk);
            rdy = pready;
            @(posedge clk);
        end
        degree_shadow = deg;
        // read back
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        rdy = 1'b0;
        rd  = '0;
        while (!rdy)
        begin
            @(negedge clk);
            rdy = pready;
            rd  = prdata;
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== {28'd0, deg})
        begin
            flag_mismatch($sformatf("degree readback: expected %0d got %h", deg, rd));
        end
    endtask

    // result checker, sampled mid-cycle
    always @(negedge clk)
    begin : result_check
        deriv_t want;
        if (rst_n && result_valid)
        begin
            if (pending_derivs.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected result %h ovf %0b",
                                        result_value, overflow));
            end
            else
            begin
                want = pending_derivs.pop_front();
                if (result_value !== want.value || overflow !== want.ovf)
                begin
                    flag_mismatch($sformatf(
                        "derivative mismatch: expected %h ovf %0b, got %h ovf %0b",
                        want.value, want.ovf, result_value, overflow));
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(negedge clk)
    begin
        if ((start && !busy) || result_valid || (psel && penable))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles = idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        deriv_t      typed_res;
        int unsigned deg;
        int unsigned gap_pct;
        int unsigned k;
        for (int i = 0; i < 16; i++)
        begin
            coef_shadow[i] = 32'sd0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int r = 0; r < N_DIRECTED; r++)
        begin
            typed_res.value = directed_rows[r].exp_val;
            typed_res.ovf   = directed_rows[r].exp_ovf;
            case (directed_rows[r].kind)
                ROW_CFG:
                begin
                    write_degree(directed_rows[r].num);
                end
                ROW_LOAD:
                begin
                    issue_item(OP_LOAD, directed_rows[r].num, directed_rows[r].cval,
                               directed_rows[r].xval, directed_rows[r].k, 1'b0, typed_res);
                end
                default:
                begin
                    issue_item(OP_EVAL, directed_rows[r].num, directed_rows[r].cval,
                               directed_rows[r].xval, directed_rows[r].k,
                               directed_rows[r].known, typed_res);
                end
            endcase
        end

        // random phases, one degree each; the last one runs without gaps
        typed_res = '0;
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase == 0 || phase == NUM_PHASES - 3)
            begin
                deg = 0;
            end
            else if (phase == 1 || phase == NUM_PHASES - 1)
            begin
                deg = 15;
            end
            else
            begin
                deg = $urandom_range(0, 15);
            end
            write_degree(4'(deg));
            gap_pct = (phase == NUM_PHASES - 1) ? 0 : 20 * $urandom_range(0, 2);
            for (int n = 0; n < PER_PHASE; n++)
            begin
                if ($urandom_range(0, 99) < gap_pct)
                begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 5)) @(posedge clk);
                end
                if ($urandom_range(0, 99) < 45)
                begin
                    issue_item(OP_LOAD, 4'($urandom_range(0, 15)), pick_q16(32'd524288),
                               $urandom, 5'($urandom), 1'b0, typed_res);
                end
                else
                begin
                    k = ($urandom_range(0, 99) < 85) ? $urandom_range(0, deg)
                                                      : $urandom_range(0, 31);
                    issue_item(OP_EVAL, 4'($urandom), $urandom, pick_q16(32'd131072),
                               5'(k), 1'b0, typed_res);
                end
            end
        end

        // drain and settle
        start <= 1'b0;
        while (pending_derivs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && pending_derivs.size() == 0)
        begin
            $display("tb OK");
        end
        else
        begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

// File: poly_derivative_horner_eval_top.f
src/phd_pkg.sv
src/phd_coef_store.sv
src/phd_mul_unit.sv
src/phd_ctrl.sv
src/poly_derivative_horner_eval_top.sv
src/phd_checker.sv
tb/tb.sv
